[sv/tcil_pkg.sv]
package tcil_pkg;

  localparam int NCH       = 3;   // horizontal EOG, vertical EOG, EMG
  localparam int CH_W      = 2;
  localparam int XW        = 14;  // scaled input sample
  localparam int VW        = 14;  // packed channel value
  localparam int BYTE_W    = 8;
  localparam int HALF_V    = VW / 2;
  localparam int HIST_W    = 40;  // Q16 output history
  localparam int HALF      = HIST_W / 2;
  localparam int FRAC_BITS = 16;
  localparam int COEF_W    = FRAC_BITS + 3;
  localparam int NTAP      = 3;

  localparam int BP_W   = XW + 1 + COEF_W;
  localparam int BSUM_W = BP_W + 2;
  localparam int FL_W   = HALF + 1 + COEF_W;
  localparam int FLS_W  = FL_W + 2;
  localparam int FH_W   = HIST_W - HALF + COEF_W;
  localparam int FHS_W  = FH_W + 2;
  localparam int ACC_W  = 64;

  localparam int SCALE_MUL = 9000;
  localparam int SCALE_OFS = 2500;
  localparam int VAL_MAX   = (1 << VW) - 1;

  localparam int QDEPTH = 2;

  localparam int ADDR_W       = 3;
  localparam int REG_SEL_BIT  = 2;
  localparam int DATA_W       = 32;
  localparam logic REG_OFFSET = 1'b0;
  localparam logic REG_HEADER = 1'b1;
  localparam logic [VW-1:0]     OFFSET_RST = VW'(4350);
  localparam logic [BYTE_W-1:0] HEADER_RST = BYTE_W'(129);

  typedef logic [CH_W-1:0] tcil_ch_t;
  localparam tcil_ch_t CH_H = 2'd0;
  localparam tcil_ch_t CH_V = 2'd1;
  localparam tcil_ch_t CH_E = 2'd2;

  typedef logic [XW-1:0] tcil_x_t;
  typedef tcil_x_t [NCH-1:0] tcil_xvec_t;
  typedef logic [VW-1:0] tcil_val_t;
  typedef tcil_val_t [NCH-1:0] tcil_vvec_t;
  typedef logic signed [COEF_W-1:0] tcil_coef_t;
  typedef logic signed [HIST_W-1:0] tcil_hist_t;

  // one computed packet handed from the filter engine to the serializer
  typedef struct packed {
    logic       valid;
    tcil_vvec_t vals;
  } tcil_pkt_t;

  localparam longint QS = 64'sd1 <<< FRAC_BITS;

  // round(e4 / 10000 * 2^F), half away from zero, for positive e4
  function automatic tcil_coef_t qpos(input longint e4);
    longint q;
    q = (e4 * QS + 64'sd5000) / 64'sd10000;
    return COEF_W'(q);
  endfunction

  // set 0: 10 Hz (EOG), set 1: 100 Hz (EMG)
  localparam tcil_coef_t COEF_B [2][4] = '{
    '{qpos(16), qpos(47), qpos(47), qpos(16)},
    '{qpos(985), qpos(2956), qpos(2956), qpos(985)}
  };
  // feedback terms, negated denominator a1..a3
  localparam tcil_coef_t COEF_F [2][NTAP] = '{
    '{qpos(24986), -qpos(21153), qpos(6041)},
    '{qpos(5772), -qpos(4218), qpos(563)}
  };

  localparam logic signed [ACC_W-1:0] HIST_MAX_A =
    {{(ACC_W-HIST_W+1){1'b0}}, {(HIST_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] HIST_MIN_A =
    {{(ACC_W-HIST_W+1){1'b1}}, {(HIST_W-1){1'b0}}};
  localparam logic [HIST_W:0] FRAC_MASK = (HIST_W+1)'((64'd1 << FRAC_BITS) - 1);

endpackage

[sv/tcil_front.sv]
module tcil_front #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_BITS-1:0]  in_sample_horizontal,
  input  logic [SAMPLE_BITS-1:0]  in_sample_vertical,
  input  logic [SAMPLE_BITS-1:0]  in_sample_emg,
  output logic                    q_valid,
  output tcil_pkg::tcil_xvec_t    q_data,
  input  logic                    q_pop
);
  import tcil_pkg::*;

  localparam int PW    = SAMPLE_BITS + XW;
  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  tcil_xvec_t       mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  tcil_xvec_t       scaled;
  logic             push;

  // floor(code * 9000 / 2^SAMPLE_BITS) + 2500
  function automatic tcil_x_t scale(input logic [SAMPLE_BITS-1:0] code);
    logic [PW-1:0] prod;
    prod = PW'(code) * PW'(SCALE_MUL);
    return prod[SAMPLE_BITS +: XW] + XW'(SCALE_OFS);
  endfunction

  assign scaled[CH_H] = scale(in_sample_horizontal);
  assign scaled[CH_V] = scale(in_sample_vertical);
  assign scaled[CH_E] = scale(in_sample_emg);

  assign in_stall = (cnt_r == CNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= scaled;
    end
  end

endmodule

[sv/tcil_filter.sv]
module tcil_filter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  tcil_pkg::tcil_xvec_t q_data,
  output logic                 q_pop,
  input  tcil_pkg::tcil_val_t  offset,
  output tcil_pkg::tcil_pkt_t  pkt,
  input  logic                 pkt_take
);
  import tcil_pkg::*;

  // sequencer
  logic       busy_r, busy_nxt;
  logic       iss_act_r, iss_act_nxt;
  tcil_ch_t   iss_ch_r, iss_ch_nxt;
  tcil_xvec_t xin_r;
  logic       start;

  // per-channel history
  tcil_x_t    xh_r [NCH][NTAP];
  tcil_hist_t yh_r [NCH][NTAP];

  // stage 1: products
  logic                    p1_v_r;
  tcil_ch_t                p1_ch_r;
  logic signed [BP_W-1:0]  bp_r   [NTAP+1];
  logic signed [BP_W-1:0]  bp_nxt [NTAP+1];
  logic signed [FL_W-1:0]  fl_r   [NTAP];
  logic signed [FL_W-1:0]  fl_nxt [NTAP];
  logic signed [FH_W-1:0]  fh_r   [NTAP];
  logic signed [FH_W-1:0]  fh_nxt [NTAP];
  tcil_x_t                 cur_x;
  logic                    set_sel;

  // stage 2: partial sums
  logic                     p2_v_r;
  tcil_ch_t                 p2_ch_r;
  logic signed [BSUM_W-1:0] bsum_r, bsum_nxt;
  logic signed [FLS_W-1:0]  flsum_r, flsum_nxt;
  logic signed [FHS_W-1:0]  fhsum_r, fhsum_nxt;

  // stage 3: full Q32 accumulator
  logic                    p3_v_r;
  tcil_ch_t                p3_ch_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  // stage 4: floored, saturated output
  logic                    p4_v_r;
  tcil_ch_t                p4_ch_r;
  tcil_hist_t              y_r, y_nxt;
  logic signed [ACC_W-1:0] ysh;

  // stage 5: truncate, offset, clamp
  logic signed [HIST_W:0]            yb;
  logic signed [HIST_W-FRAC_BITS:0]  tq;
  logic signed [HIST_W-FRAC_BITS+1:0] vsum;
  logic signed [HIST_W-FRAC_BITS+1:0] offs_ext;
  tcil_val_t                         val_nxt;
  tcil_vvec_t                        pkt_vals_r;
  logic                              pkt_valid_r, pkt_valid_nxt;

  assign start = q_valid && !busy_r && !pkt_valid_r;
  assign q_pop = start;

  always_comb begin
    busy_nxt    = busy_r;
    iss_act_nxt = iss_act_r;
    iss_ch_nxt  = iss_ch_r;
    if (start) begin
      busy_nxt    = 1'b1;
      iss_act_nxt = 1'b1;
      iss_ch_nxt  = CH_H;
    end else if (iss_act_r) begin
      if (iss_ch_r == CH_E) begin
        iss_act_nxt = 1'b0;
      end else begin
        iss_ch_nxt = iss_ch_r + 1'b1;
      end
    end
    // last channel leaves stage 5 at this edge
    if (p4_v_r && p4_ch_r == CH_E) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    pkt_valid_nxt = pkt_valid_r;
    if (p4_v_r && p4_ch_r == CH_E) begin
      pkt_valid_nxt = 1'b1;
    end else if (pkt_take) begin
      pkt_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      iss_act_r   <= 1'b0;
      iss_ch_r    <= CH_H;
      pkt_valid_r <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      p4_v_r      <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      iss_act_r   <= iss_act_nxt;
      iss_ch_r    <= iss_ch_nxt;
      pkt_valid_r <= pkt_valid_nxt;
      p1_v_r      <= iss_act_r;
      p2_v_r      <= p1_v_r;
      p3_v_r      <= p2_v_r;
      p4_v_r      <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xin_r <= q_data;
    end
  end

  // stage 1
  assign cur_x   = xin_r[iss_ch_r];
  assign set_sel = (iss_ch_r == CH_E);

  always_comb begin
    bp_nxt[0] = $signed({1'b0, cur_x}) * COEF_B[set_sel][0];
    for (int i = 0; i < NTAP; i++) begin
      bp_nxt[i+1] = $signed({1'b0, xh_r[iss_ch_r][i]}) * COEF_B[set_sel][i+1];
      // y = hi * 2^HALF + lo, lo unsigned
      fl_nxt[i] = $signed({1'b0, yh_r[iss_ch_r][i][HALF-1:0]}) * COEF_F[set_sel][i];
      fh_nxt[i] = $signed(yh_r[iss_ch_r][i][HIST_W-1:HALF]) * COEF_F[set_sel][i];
    end
  end

  always_ff @(posedge clk) begin
    p1_ch_r <= iss_ch_r;
    for (int i = 0; i <= NTAP; i++) begin
      bp_r[i] <= bp_nxt[i];
    end
    for (int i = 0; i < NTAP; i++) begin
      fl_r[i] <= fl_nxt[i];
      fh_r[i] <= fh_nxt[i];
    end
  end

  // stage 2
  always_comb begin
    bsum_nxt  = '0;
    flsum_nxt = '0;
    fhsum_nxt = '0;
    for (int i = 0; i <= NTAP; i++) begin
      bsum_nxt = bsum_nxt + BSUM_W'(bp_r[i]);
    end
    for (int i = 0; i < NTAP; i++) begin
      flsum_nxt = flsum_nxt + FLS_W'(fl_r[i]);
      fhsum_nxt = fhsum_nxt + FHS_W'(fh_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    p2_ch_r <= p1_ch_r;
    bsum_r  <= bsum_nxt;
    flsum_r <= flsum_nxt;
    fhsum_r <= fhsum_nxt;
  end

  // stage 3
  assign acc_nxt = (ACC_W'(bsum_r) <<< FRAC_BITS) + ACC_W'(flsum_r)
                 + (ACC_W'(fhsum_r) <<< HALF);

  always_ff @(posedge clk) begin
    p3_ch_r <= p2_ch_r;
    acc_r   <= acc_nxt;
  end

  // stage 4: floor to Q16, saturate to the history range
  assign ysh = acc_r >>> FRAC_BITS;

  always_comb begin
    if (ysh > HIST_MAX_A) begin
      y_nxt = HIST_W'(HIST_MAX_A);
    end else if (ysh < HIST_MIN_A) begin
      y_nxt = HIST_W'(HIST_MIN_A);
    end else begin
      y_nxt = HIST_W'(ysh);
    end
  end

  always_ff @(posedge clk) begin
    p4_ch_r <= p3_ch_r;
    y_r     <= y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) begin
        for (int i = 0; i < NTAP; i++) begin
          xh_r[c][i] <= '0;
          yh_r[c][i] <= '0;
        end
      end
    end else begin
      if (iss_act_r) begin
        xh_r[iss_ch_r][0] <= cur_x;
        for (int i = 1; i < NTAP; i++) begin
          xh_r[iss_ch_r][i] <= xh_r[iss_ch_r][i-1];
        end
      end
      if (p3_v_r) begin
        yh_r[p3_ch_r][0] <= y_nxt;
        for (int i = 1; i < NTAP; i++) begin
          yh_r[p3_ch_r][i] <= yh_r[p3_ch_r][i-1];
        end
      end
    end
  end

  // stage 5: toward-zero integer part, add offset, clamp
  always_comb begin
    yb       = (HIST_W+1)'(y_r) + (y_r[HIST_W-1] ? FRAC_MASK : '0);
    tq       = (HIST_W-FRAC_BITS+1)'(yb >>> FRAC_BITS);
    offs_ext = $signed({{(HIST_W-FRAC_BITS+2-VW){1'b0}}, offset});
    vsum     = (HIST_W-FRAC_BITS+2)'(tq) + offs_ext;
    if (vsum < 0) begin
      val_nxt = '0;
    end else if (vsum > (HIST_W-FRAC_BITS+2)'(VAL_MAX)) begin
      val_nxt = VW'(VAL_MAX);
    end else begin
      val_nxt = VW'(vsum);
    end
  end

  always_ff @(posedge clk) begin
    if (p4_v_r) begin
      pkt_vals_r[p4_ch_r] <= val_nxt;
    end
  end

  assign pkt.valid = pkt_valid_r;
  assign pkt.vals  = pkt_vals_r;

endmodule

[sv/tcil_emit.sv]
module tcil_emit #(
  parameter int PACKET_LENGTH = 13
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tcil_pkg::tcil_pkt_t         pkt,
  output logic                        pkt_take,
  input  logic [tcil_pkg::BYTE_W-1:0] header,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tcil_pkg::BYTE_W-1:0] out_packet_byte,
  output logic                        out_last_byte
);
  import tcil_pkg::*;

  localparam int IDX_W = $clog2(PACKET_LENGTH);

  logic                busy_r, busy_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  tcil_vvec_t          vals_r;
  logic [BYTE_W-1:0]   hdr_r;
  logic                fire;
  logic                last;
  logic                load;
  logic [IDX_W-1:0]    k;
  tcil_ch_t            ch;
  tcil_val_t           v;

  assign last     = (idx_r == IDX_W'(PACKET_LENGTH - 1));
  assign fire     = busy_r && !out_stall;
  assign load     = pkt.valid && (!busy_r || (fire && last));
  assign pkt_take = load;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (fire) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vals_r <= pkt.vals;
      hdr_r  <= header;
    end
  end

  // byte 0 header, then high/low 7 bits per channel, then zero fill
  always_comb begin
    k  = idx_r - 1'b1;
    ch = CH_W'(k >> 1);
    v  = vals_r[ch];
    out_packet_byte = '0;
    if (idx_r == '0) begin
      out_packet_byte = hdr_r;
    end else if (idx_r <= IDX_W'(2 * NCH)) begin
      if (idx_r[0]) begin
        out_packet_byte = BYTE_W'(v[VW-1:HALF_V]);
      end else begin
        out_packet_byte = BYTE_W'(v[HALF_V-1:0]);
      end
    end
  end

  assign out_valid     = busy_r;
  assign out_last_byte = last;

endmodule

[sv/three_channel_iir_lowpass_packetizer_unit.sv]
// Three-channel third-order IIR low-pass with packet output. Each accepted tick
// (three raw converter codes) yields one packet of PACKET_LENGTH bytes: the
// header register, high/low 7 bits of the horizontal, vertical and EMG values,
// then zeros, with out_last_byte on the final byte. Sustained rate is set by the
// output serializer, which sends one byte per cycle while out_stall is low and
// starts the next packet right after the last byte of the one before. The
// filter engine takes a new tick only after handing its previous packet to the
// serializer: three channels issued into a 5-stage multiply/accumulate pipeline,
// then the packet is handed over and the engine restarts. It runs while the
// previous packet is still going out. In an idle block the packet goes out as
// soon as the serializer takes it. A 2-deep input queue absorbs ticks while the
// engine is busy. Histories clear on reset; registers are set via the APB port.
module three_channel_iir_lowpass_packetizer_unit #(
  parameter int SAMPLE_BITS   = 12,
  parameter int PACKET_LENGTH = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [SAMPLE_BITS-1:0]        in_sample_horizontal,
  input  logic [SAMPLE_BITS-1:0]        in_sample_vertical,
  input  logic [SAMPLE_BITS-1:0]        in_sample_emg,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcil_pkg::BYTE_W-1:0]   out_packet_byte,
  output logic                          out_last_byte,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcil_pkg::ADDR_W-1:0]   paddr,
  input  logic [tcil_pkg::DATA_W-1:0]   pwdata,
  output logic [tcil_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import tcil_pkg::*;

  logic              q_valid;
  tcil_xvec_t        q_data;
  logic              q_pop;
  tcil_pkt_t         pkt;
  logic              pkt_take;
  tcil_val_t         offset_r, offset_nxt;
  logic [BYTE_W-1:0] header_r, header_nxt;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    offset_nxt = offset_r;
    header_nxt = header_r;
    if (cfg_wr) begin
      case (paddr[REG_SEL_BIT])
        REG_OFFSET: offset_nxt = pwdata[VW-1:0];
        REG_HEADER: header_nxt = pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RST;
      header_r <= HEADER_RST;
    end else begin
      offset_r <= offset_nxt;
      header_r <= header_nxt;
    end
  end

  always_comb begin
    case (paddr[REG_SEL_BIT])
      REG_OFFSET: prdata = DATA_W'(offset_r);
      REG_HEADER: prdata = DATA_W'(header_r);
      default:    prdata = '0;
    endcase
  end

  tcil_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_horizontal(in_sample_horizontal),
    .in_sample_vertical  (in_sample_vertical),
    .in_sample_emg       (in_sample_emg),
    .q_valid             (q_valid),
    .q_data              (q_data),
    .q_pop               (q_pop)
  );

  tcil_filter u_filter (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .offset  (offset_r),
    .pkt     (pkt),
    .pkt_take(pkt_take)
  );

  tcil_emit #(
    .PACKET_LENGTH(PACKET_LENGTH)
  ) u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .pkt            (pkt),
    .pkt_take       (pkt_take),
    .header         (header_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_packet_byte(out_packet_byte),
    .out_last_byte  (out_last_byte)
  );

  // engine only pulls a tick the queue actually holds
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

  // serializer only takes a finished packet
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_take |-> pkt.valid)
    else $error("packet taken while none ready");

  // engine cannot refill the packet slot right after a handoff
  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_take |=> !pkt.valid)
    else $error("packet slot refilled too early");

  // a new packet only starts once the previous one ends with its last byte
  a_take_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (pkt_take && out_valid) |-> (out_last_byte && !out_stall))
    else $error("packet handoff in the middle of a packet");

endmodule
